// File: hw/rtl/rttu_pkg.sv
package rttu_pkg;

    localparam int MAX_RADIX_DEF  = 16;
    localparam int MAX_PREFIX_DEF = 2;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [63:0] DIGIT_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DIGIT_HIGH_RST = 64'h6665_6463_6261_3938;
    localparam logic [4:0]  RADIX_RST      = 5'd10;

    typedef struct packed {
        logic [63:0] digit_chars_low;
        logic [63:0] digit_chars_high;
        logic [4:0]  radix_in_use;
        logic [15:0] prefix_chars;
        logic [1:0]  prefix_len;
    } cfg_t;

    // ascii letters A to Z fold to lower case, everything else passes
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/radix_text_to_unsigned.sv
// a zero byte is registered in char_reg, then the value loads the result register
// throughput: one character per cycle unless stalled; one multiply-add per character
// the only stall comes from a zero byte meeting a full result register under stall
// reset (rst_n low, asynchronous) empties both registers, returns to skipping whitespace,
// clears the accumulator and loads the default decimal digit table with no prefix
module radix_text_to_unsigned #(
    parameter int MAX_RADIX  = rttu_pkg::MAX_RADIX_DEF,
    parameter int MAX_PREFIX = rttu_pkg::MAX_PREFIX_DEF,
    parameter int VALUE_BITS = rttu_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] parsed_value
);

    rttu_pkg::cfg_t              cfg;
    logic [VALUE_BITS-1:0]       result_value;
    logic [VALUE_BITS+31:0]      result_ext;

    rttu_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    rttu_core #(
        .MAX_RADIX (MAX_RADIX),
        .MAX_PREFIX(MAX_PREFIX),
        .VALUE_BITS(VALUE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_code   (char_code),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_value(result_value)
    );

    // low 32 bits of the result value, zero filled when it is narrower
    assign result_ext   = {32'd0, result_value};
    assign parsed_value = result_ext[31:0];

endmodule

// File: hw/rtl/rttu_cfg.sv
module rttu_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output rttu_pkg::cfg_t     cfg
);

    localparam logic [2:0] REG_DIGIT_LOW  = 3'd0;
    localparam logic [2:0] REG_DIGIT_HIGH = 3'd1;
    localparam logic [2:0] REG_RADIX      = 3'd2;
    localparam logic [2:0] REG_PREFIX     = 3'd3;
    localparam logic [2:0] REG_PREFIX_LEN = 3'd4;

    rttu_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digit_chars_low  <= rttu_pkg::DIGIT_LOW_RST;
            cfg_reg.digit_chars_high <= rttu_pkg::DIGIT_HIGH_RST;
            cfg_reg.radix_in_use     <= rttu_pkg::RADIX_RST;
            cfg_reg.prefix_chars     <= 16'd0;
            cfg_reg.prefix_len       <= 2'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_DIGIT_LOW:  cfg_reg.digit_chars_low  <= pwdata;
                REG_DIGIT_HIGH: cfg_reg.digit_chars_high <= pwdata;
                REG_RADIX:      cfg_reg.radix_in_use     <= pwdata[4:0];
                REG_PREFIX:     cfg_reg.prefix_chars     <= pwdata[15:0];
                REG_PREFIX_LEN: cfg_reg.prefix_len       <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DIGIT_LOW:  prdata = cfg_reg.digit_chars_low;
            REG_DIGIT_HIGH: prdata = cfg_reg.digit_chars_high;
            REG_RADIX:      prdata = 64'(cfg_reg.radix_in_use);
            REG_PREFIX:     prdata = 64'(cfg_reg.prefix_chars);
            REG_PREFIX_LEN: prdata = 64'(cfg_reg.prefix_len);
            default:        prdata = 64'd0;
        endcase
    end

endmodule

// File: hw/rtl/rttu_digit_lookup.sv
module rttu_digit_lookup #(
    parameter int MAX_RADIX = rttu_pkg::MAX_RADIX_DEF,
    localparam int DIGIT_W  = $clog2(MAX_RADIX)
) (
    input  logic [7:0]         char_code,
    input  logic [127:0]       digit_table,
    input  logic [4:0]         radix,
    output logic               hit,
    output logic [DIGIT_W-1:0] digit
);

    logic [7:0] key;

    assign key = rttu_pkg::fold(char_code);

    // parallel compare, walked from the top so the lowest matching entry wins
    always_comb
    begin
        hit   = 1'b0;
        digit = '0;
        for (int i = MAX_RADIX - 1; i >= 0; i--)
        begin
            if (5'(i) < radix && rttu_pkg::fold(digit_table[i*8 +: 8]) == key)
            begin
                hit   = 1'b1;
                digit = DIGIT_W'(i);
            end
        end
    end

endmodule

// File: hw/rtl/rttu_core.sv
module rttu_core #(
    parameter int MAX_RADIX  = rttu_pkg::MAX_RADIX_DEF,
    parameter int MAX_PREFIX = rttu_pkg::MAX_PREFIX_DEF,
    parameter int VALUE_BITS = rttu_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rttu_pkg::cfg_t        cfg,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  logic [7:0]            char_code,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [VALUE_BITS-1:0] result_value
);

    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int PIDX_W  = $clog2(MAX_PREFIX + 2);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_PREFIX,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            char_reg, char_next;
    phase_t                phase_reg, phase_next;
    logic [PIDX_W-1:0]     pidx_reg, pidx_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;

    logic [4:0]            eff_radix;
    logic [1:0]            eff_plen;
    logic                  is_end;
    logic                  is_space;
    logic                  proc_fire;
    logic                  char_take;
    logic                  dig_hit;
    logic [DIGIT_W-1:0]    dig_val;
    logic [VALUE_BITS-1:0] acc_mac;
    logic [PIDX_W-1:0]     pidx_use;
    logic [PIDX_W-1:0]     pidx_inc;
    logic [7:0]            want;
    logic                  pfx_match;
    logic                  pfx_done;

    assign eff_radix = (cfg.radix_in_use > 5'(MAX_RADIX)) ? 5'(MAX_RADIX)
                                                          : cfg.radix_in_use;
    assign eff_plen  = (cfg.prefix_len > 2'(MAX_PREFIX)) ? 2'(MAX_PREFIX)
                                                         : cfg.prefix_len;

    rttu_digit_lookup #(
        .MAX_RADIX(MAX_RADIX)
    ) u_lookup (
        .char_code  (char_reg),
        .digit_table({cfg.digit_chars_high, cfg.digit_chars_low}),
        .radix      (eff_radix),
        .hit        (dig_hit),
        .digit      (dig_val)
    );

    assign is_end   = (char_reg == 8'd0);
    assign is_space = (char_reg == 8'h20) || (char_reg >= 8'd9 && char_reg <= 8'd13);

    // an end request needs the result register free or draining
    assign proc_fire  = in_valid_reg && (!is_end || !out_valid_reg || !result_stall);
    assign char_stall = in_valid_reg && !proc_fire;
    assign char_take  = char_valid && !char_stall;

    assign acc_mac = acc_reg * VALUE_BITS'(eff_radix) + VALUE_BITS'(dig_val);

    // the first prefix character is compared straight out of the skip phase
    assign pidx_use  = (phase_reg == PH_SKIP) ? '0 : pidx_reg;
    assign pidx_inc  = pidx_use + PIDX_W'(1);
    assign want      = pidx_use[0] ? cfg.prefix_chars[15:8] : cfg.prefix_chars[7:0];
    assign pfx_match = rttu_pkg::fold(char_reg) == rttu_pkg::fold(want);
    assign pfx_done  = 3'(pidx_inc) >= {1'b0, eff_plen};

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        char_next      = char_reg;
        phase_next     = phase_reg;
        pidx_next      = pidx_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (char_take)
        begin
            in_valid_next = 1'b1;
            char_next     = char_code;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end

        if (proc_fire)
        begin
            if (is_end)
            begin
                out_valid_next = 1'b1;
                out_value_next = acc_reg;
                phase_next     = PH_SKIP;
                pidx_next      = '0;
                acc_next       = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SKIP, PH_PREFIX, PH_DIGITS:
                    begin
                        if (phase_reg == PH_SKIP && is_space)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (phase_reg == PH_DIGITS
                                 || (phase_reg == PH_SKIP && eff_plen == 2'd0))
                        begin
                            if (dig_hit)
                            begin
                                acc_next   = acc_mac;
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        else if (!pfx_match)
                        begin
                            acc_next   = '0;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            pidx_next  = pidx_inc;
                            phase_next = pfx_done ? PH_DIGITS : PH_PREFIX;
                        end
                    end
                    PH_STOP: phase_next = PH_STOP;
                    default: phase_next = PH_STOP;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            char_reg      <= 8'd0;
            phase_reg     <= PH_SKIP;
            pidx_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            char_reg      <= char_next;
            phase_reg     <= phase_next;
            pidx_reg      <= pidx_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;

endmodule

// File: sim/radix_text_to_unsigned_chk.sv
`timescale 1ns / 100ps

package rttu_tb_pkg;

    // register indexes, byte address is index * 8
    typedef enum logic [2:0] {
        REG_DIGITS_LOW   = 3'd0,
        REG_DIGITS_HIGH  = 3'd1,
        REG_RADIX        = 3'd2,
        REG_PREFIX_CHARS = 3'd3,
        REG_PREFIX_LEN   = 3'd4
    } reg_index_e;

    localparam logic [7:0] END_OF_TEXT = 8'h00;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] TAB_CHAR    = 8'h09;
    localparam logic [7:0] CR_CHAR     = 8'h0D;

endpackage

module radix_text_to_unsigned_chk
    import rttu_pkg::*;
    import rttu_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        char_valid,
    input  logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] parsed_value,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [1:0] {
        SKIP_SPACE   = 2'd0,
        MATCH_PREFIX = 2'd1,
        TAKE_DIGITS  = 2'd2,
        STOPPED      = 2'd3
    } parse_phase_e;

    logic [127:0] digit_row;
    logic [4:0]   radix_cfg;
    logic [15:0]  prefix_cfg;
    logic [1:0]   prefix_len_cfg;

    parse_phase_e phase;
    logic [1:0]   prefix_pos;
    logic [31:0]  acc;

    logic [31:0]  predicted_values[$];
    int           errs = 0;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [4:0] base_eff();
        return (radix_cfg > 5'd16) ? 5'd16 : radix_cfg;
    endfunction

    function automatic logic [1:0] prefix_need();
        return (prefix_len_cfg > 2'd2) ? 2'd2 : prefix_len_cfg;
    endfunction

    task automatic take_digit_char(input logic [7:0] c);
        logic       hit;
        logic [3:0] d;
        hit = 1'b0;
        d = 4'd0;
        // first matching entry wins
        for (int i = 0; i < 16; i++)
        begin
            if (!hit && i < base_eff() && to_lower(digit_row[i*8 +: 8]) == to_lower(c))
            begin
                hit = 1'b1;
                d = 4'(i);
            end
        end
        if (hit)
        begin
            acc = acc * {27'd0, base_eff()} + {28'd0, d};
        end
        else
        begin
            phase = STOPPED;
        end
    endtask

    task automatic take_prefix_char(input logic [7:0] c);
        logic [7:0] want;
        want = prefix_pos[0] ? prefix_cfg[15:8] : prefix_cfg[7:0];
        if (to_lower(c) != to_lower(want))
        begin
            acc = 32'd0;
            phase = STOPPED;
        end
        else
        begin
            prefix_pos = prefix_pos + 2'd1;
            if (prefix_pos >= prefix_need())
            begin
                phase = TAKE_DIGITS;
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        if (c == END_OF_TEXT)
        begin
            predicted_values.push_back(acc);
            phase = SKIP_SPACE;
            prefix_pos = 2'd0;
            acc = 32'd0;
        end
        else
        begin
            case (phase)
                SKIP_SPACE:
                begin
                    if (!(c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR)))
                    begin
                        prefix_pos = 2'd0;
                        if (prefix_need() == 2'd0)
                        begin
                            phase = TAKE_DIGITS;
                            take_digit_char(c);
                        end
                        else
                        begin
                            phase = MATCH_PREFIX;
                            take_prefix_char(c);
                        end
                    end
                end
                MATCH_PREFIX: take_prefix_char(c);
                TAKE_DIGITS:  take_digit_char(c);
                default:      ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch, %s: got %08h, expected %08h", $realtime, what, got, want);
        errs++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_row      = {DIGIT_HIGH_RST, DIGIT_LOW_RST};
            radix_cfg      = RADIX_RST;
            prefix_cfg     = 16'd0;
            prefix_len_cfg = 2'd0;
            phase          = SKIP_SPACE;
            prefix_pos     = 2'd0;
            acc            = 32'd0;
            predicted_values.delete();
            fail_count <= errs;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_e'(paddr[5:3]))
                    REG_DIGITS_LOW:   digit_row[63:0]   = pwdata;
                    REG_DIGITS_HIGH:  digit_row[127:64] = pwdata;
                    REG_RADIX:        radix_cfg         = pwdata[4:0];
                    REG_PREFIX_CHARS: prefix_cfg        = pwdata[15:0];
                    REG_PREFIX_LEN:   prefix_len_cfg    = pwdata[1:0];
                    default:          ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (predicted_values.size() == 0)
                begin
                    report_mismatch("result with nothing pending", parsed_value, 32'd0);
                end
                else
                begin
                    if (parsed_value !== predicted_values[0])
                    begin
                        report_mismatch("parsed_value", parsed_value, predicted_values[0]);
                    end
                    void'(predicted_values.pop_front());
                end
            end
            if (char_valid && !char_stall)
            begin
                parse_char(char_code);
            end
            fail_count <= errs;
            pending    <= predicted_values.size();
        end
    end

endmodule

// File: sim/radix_text_to_unsigned_tb.sv
`timescale 1ns / 100ps

module radix_text_to_unsigned_tb;

    import rttu_pkg::*;
    import rttu_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        char_valid;
    logic        char_stall;
    logic [7:0]  char_code;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] parsed_value;

    int          fail_count;
    int          pending;

    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    int          sent_items = 0;

    // copy of the current setting, used only to build well-formed text
    logic [63:0] cur_low;
    logic [63:0] cur_high;
    logic [4:0]  cur_radix;
    logic [15:0] cur_prefix;
    logic [1:0]  cur_plen;

    radix_text_to_unsigned DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .parsed_value (parsed_value)
    );

    radix_text_to_unsigned_chk chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .parsed_value (parsed_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ($urandom_range(0, 1) == 1)
        begin
            if (c >= 8'h61 && c <= 8'h7A)
            begin
                r = c - 8'h20;
            end
            else if (c >= 8'h41 && c <= 8'h5A)
            begin
                r = c + 8'h20;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 2))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'h41 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? SPACE_CHAR : 8'(r);
    endfunction

    function automatic logic [7:0] digit_for();
        logic [127:0] row;
        logic [7:0]   e;
        int           base;
        row = {cur_high, cur_low};
        base = (cur_radix > 5'd16) ? 16 : int'(cur_radix);
        if (base == 0)
        begin
            return 8'($urandom_range(1, 255));
        end
        e = row[$urandom_range(0, base - 1)*8 +: 8];
        if (e == END_OF_TEXT)
        begin
            e = 8'($urandom_range(1, 255));
        end
        return swap_case(e);
    endfunction

    // called at a rising edge, returns at the edge that accepts the request
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        @(posedge clk);
        while (char_stall)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
        send_char(END_OF_TEXT);
    endtask

    task automatic write_reg(input reg_index_e idx, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic pick_config();
        case ($urandom_range(0, 7))
            0:       cur_radix = 5'd0;
            1:       cur_radix = 5'd1;
            2:       cur_radix = 5'd2;
            3:       cur_radix = 5'd16;
            4:       cur_radix = 5'($urandom_range(17, 31));
            default: cur_radix = 5'($urandom_range(3, 15));
        endcase
        cur_plen = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
        begin
            cur_prefix = 16'($urandom);
        end
        else
        begin
            cur_prefix = {text_char(), text_char()};
        end
        if ($urandom_range(0, 3) == 0)
        begin
            cur_low  = {$urandom, $urandom};
            cur_high = {$urandom, $urandom};
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                cur_low[i*8 +: 8]  = text_char();
                cur_high[i*8 +: 8] = text_char();
            end
        end
        write_reg(REG_DIGITS_LOW, cur_low);
        write_reg(REG_DIGITS_HIGH, cur_high);
        write_reg(REG_RADIX, {59'd0, cur_radix});
        write_reg(REG_PREFIX_CHARS, {48'd0, cur_prefix});
        write_reg(REG_PREFIX_LEN, {62'd0, cur_plen});
    endtask

    // mostly well-formed: blanks, prefix, digits; some noise, bad prefix or bad digit
    task automatic send_random_string(input bit short_text);
        logic [7:0] c;
        int         kind;
        int         n;
        int         plen;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) send_char(blank_char());
            plen = (cur_plen > 2'd2) ? 2 : int'(cur_plen);
            for (int k = 0; k < plen; k++)
            begin
                c = (k == 0) ? cur_prefix[7:0] : cur_prefix[15:8];
                if (kind == 1 && k == 0)
                begin
                    c = 8'($urandom_range(1, 255));
                end
                if (c == END_OF_TEXT)
                begin
                    c = 8'h30;
                end
                send_char(swap_case(c));
            end
            n = short_text ? $urandom_range(1, 2) : $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
            begin
                c = digit_for();
                if (kind == 2 && k == n / 2)
                begin
                    c = 8'($urandom_range(1, 255));
                end
                send_char(c);
            end
        end
        send_char(END_OF_TEXT);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_go)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_go = 1'b0;
            end
            else
            begin
                n = calm ? 0 : pick_gap();
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int start_count;
        int phase_no;
        int nstr;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 6'd0;
        pwdata     = 64'd0;
        char_valid = 1'b0;
        char_code  = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: decimal, no prefix; blanks then a bad digit freezes the value
        send_char(SPACE_CHAR);
        send_char(TAB_CHAR);
        send_char(CR_CHAR);
        send_text("7x9");
        send_char(END_OF_TEXT);
        settle();

        // hex with a two-character prefix, upper case in the table
        write_reg(REG_DIGITS_LOW, 64'h3736_3534_3332_3130);
        write_reg(REG_DIGITS_HIGH, 64'h4645_4443_4241_3938);
        write_reg(REG_RADIX, 64'd16);
        write_reg(REG_PREFIX_CHARS, 64'h7830);
        write_reg(REG_PREFIX_LEN, 64'd2);
        send_text("0XfF");
        send_text("0y1");
        send_text("0");
        settle();

        // radix and prefix length above their limits, codes above 127 in table
        write_reg(REG_DIGITS_HIGH, 64'h80FF_4645_4443_4241);
        write_reg(REG_RADIX, 64'd31);
        write_reg(REG_PREFIX_CHARS, 64'h6B4A);
        write_reg(REG_PREFIX_LEN, 64'd3);
        send_char(8'h6A);
        send_char(8'h4B);
        send_char(8'hFF);
        send_char(8'h80);
        send_text("c");
        settle();

        // radix zero: nothing is a digit
        write_reg(REG_RADIX, 64'd0);
        write_reg(REG_PREFIX_LEN, 64'd0);
        send_text("1");
        settle();

        start_count = sent_items;
        phase_no = 0;
        while (sent_items - start_count < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            pick_config();
            if (phase_no == 2)
            begin
                // receiver holds off while short strings keep coming
                calm = 1'b0;
                hold_go = 1'b1;
                for (int s = 0; s < 20; s++)
                begin
                    send_random_string(1'b1);
                end
            end
            else
            begin
                nstr = $urandom_range(6, 14);
                for (int s = 0; s < nstr; s++)
                begin
                    send_random_string(1'b0);
                end
            end
            settle();
            phase_no++;
        end

        repeat (6) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
